>>> hdl/rsht_pkg.sv
// Shared constants, entry types and the probe remix function of the register shadow table.
package rsht_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int IDX_W = $clog2(TABLE_SIZE);

	localparam logic [31:0] REMIX_SEED = 32'd4242427;
	localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RELOC = 2'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_KEY_ZERO = 2'd2;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
		logic [15:0] handle;
		logic [1:0]  usage;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           entry;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	function automatic logic [31:0] remix(input logic [31:0] h);
		logic [31:0] x;
		x = (h == 32'd0) ? REMIX_SEED : h;
		for (int i = 0; i < 4; i++) begin
			x = (x >> 1) ^ (x[0] ? LFSR_TAPS : 32'd0);
		end
		return x;
	endfunction

endpackage

>>> hdl/rsht_store.sv
// Slot memory with per-slot occupied bits and a registered read port.
module rsht_store
	import rsht_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd,
	input  wr_req_t wr,
	output entry_t  rd_entry,
	output logic    rd_used
);

	entry_t mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] used_q;
	entry_t rd_entry_q;
	logic rd_used_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd.en) begin
			rd_entry_q <= mem[rd.addr];
			rd_used_q <= used_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr.en) begin
			used_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_used = rd_used_q;

endmodule

>>> hdl/register_shadow_hash_table.sv
// Top level of the register shadow store: probe sequencer around the slot memory.
//
// Channel   Direction  Handshake            Payload
// command   in         start && !busy       mode, reg_offset, write_value, write_mask,
//                                           reloc_handle, reloc_usage
// result    out        done, one cycle      read_value, status
//
// An item is busy while it is probed; each probe is one read of the slot memory, and there
// are 1 to TABLE_SIZE probes. The result strobe comes once the read data of the last probe
// has been checked, and the next item may be accepted in the same cycle as that strobe. A
// zero key gives its result in the cycle after accept. Reset clears all slots at once
// through the occupied bits. The receiver cannot stall.
module register_shadow_hash_table
	import rsht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] reg_offset,
	input  logic [31:0] write_value,
	input  logic [31:0] write_mask,
	input  logic [15:0] reloc_handle,
	input  logic [1:0]  reloc_usage,
	output logic        done,
	output logic [31:0] read_value,
	output logic [1:0]  status
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_PROBE = 2'b10
	} state_t;

	state_t state_q;
	logic [31:0] h_q;
	logic [IDX_W-1:0] probe_cnt_q;
	logic [1:0] mode_q;
	logic [31:0] key_q;
	logic [31:0] val_q;
	logic [31:0] mask_q;
	logic [15:0] hdl_q;
	logic [1:0] use_q;
	logic done_q;
	logic [31:0] read_value_q;
	logic [1:0] status_q;

	rd_req_t rd;
	wr_req_t wr;
	entry_t rd_entry;
	logic rd_used;
	logic [31:0] h_next;
	logic hit;
	logic empty;
	logic is_write;
	logic is_reloc;
	logic [31:0] base_value;
	logic [31:0] new_value;
	logic accept;

	rsht_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_used  (rd_used)
	);

	assign accept = start && (state_q == S_IDLE);
	assign h_next = remix(h_q);
	assign hit = rd_used && (rd_entry.key == key_q);
	assign empty = !rd_used;
	assign is_reloc = (mode_q == MODE_RELOC);
	assign is_write = (mode_q == MODE_WRITE) || is_reloc;
	assign base_value = hit ? rd_entry.value : 32'd0;
	assign new_value = is_write ? ((base_value & ~mask_q) | (val_q & mask_q)) : base_value;

	always_comb begin
		rd = '0;
		wr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd.en = accept && (reg_offset != 32'd0);
				rd.addr = reg_offset[IDX_W-1:0];
			end
			S_PROBE: begin
				if (hit || empty) begin
					wr.en = 1'b1;
					wr.addr = h_q[IDX_W-1:0];
					wr.entry.key = key_q;
					wr.entry.value = new_value;
					if (is_reloc) begin
						wr.entry.handle = hdl_q;
						wr.entry.usage = use_q;
					end else begin
						wr.entry.handle = (is_write || !hit) ? 16'd0 : rd_entry.handle;
						wr.entry.usage = hit ? rd_entry.usage : 2'd0;
					end
				end else if (probe_cnt_q != IDX_W'(TABLE_SIZE - 1)) begin
					rd.en = 1'b1;
					rd.addr = h_next[IDX_W-1:0];
				end
			end
			default: begin
				rd = '0;
				wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (reg_offset == 32'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (hit || empty || (probe_cnt_q == IDX_W'(TABLE_SIZE - 1))) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q <= reg_offset;
			val_q <= write_value;
			mask_q <= write_mask;
			hdl_q <= reloc_handle;
			use_q <= reloc_usage;
			h_q <= reg_offset;
			probe_cnt_q <= '0;
			read_value_q <= 32'd0;
			status_q <= ST_KEY_ZERO;
		end else if (state_q == S_PROBE) begin
			if (hit || empty) begin
				read_value_q <= new_value;
				status_q <= ST_OK;
			end else if (probe_cnt_q == IDX_W'(TABLE_SIZE - 1)) begin
				read_value_q <= 32'd0;
				status_q <= ST_FULL;
			end else begin
				h_q <= h_next;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign read_value = read_value_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither probing nor finished");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still probing");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (read_value == 32'd0))
		else $error("failed access returned a nonzero value");

	a_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ((state_q == S_PROBE) && !rd.en))
		else $error("slot write outside a probe or with a read");
`endif

endmodule
